@@ hdl/banked_rom_memory_mapper_defines.svh @@
// assertion macros for the banked rom memory mapper
// used by the top level; no other dependencies
`ifndef BANKED_ROM_MEMORY_MAPPER_DEFINES_SVH
`define BANKED_ROM_MEMORY_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRMM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("brmm assertion failed");
`define BRMM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("brmm assertion failed");
`else
`define BRMM_ASSERT(lbl, clk, rst, prop)
`define BRMM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hdl/brmm_pkg.sv @@
// shared types and constants of the banked rom memory mapper
// no dependencies
`timescale 1ns / 1ps

package brmm_pkg;

  localparam int MAX_PAGES  = 256;
  localparam int PAGE_BYTES = 16384;

  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int NEFF_W     = PAGE_W + 1;
  localparam int OFFSET_W   = $clog2(PAGE_BYTES);
  localparam int ROM_ADDR_W = PAGE_W + OFFSET_W;
  localparam int CFG_W      = 9;
  localparam int BANK_W     = 8;
  localparam int STEP_W     = $clog2(BANK_W);
  localparam int BUS_W      = 16;
  localparam int DATA_W     = 8;
  localparam int RAM_DEPTH  = 8192;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int NUM_BANKS  = 4;
  localparam int NUM_SLOTS  = 3;
  localparam int BANK_IDX_W = $clog2(NUM_BANKS);

  localparam logic [BUS_W-1:0] FIXED_END = 16'h03FF;
  localparam logic [BUS_W-1:0] SLOT0_END = 16'h3FFF;
  localparam logic [BUS_W-1:0] SLOT1_END = 16'h7FFF;
  localparam logic [BUS_W-1:0] SLOT2_END = 16'hBFFF;
  localparam logic [BUS_W-1:0] BANK_BASE = 16'hFFFC;
  localparam logic [BANK_W-1:0] CART_EN_MASK = 8'h08;
  localparam logic [CFG_W-1:0] PAGE_CNT_RESET = 9'd1;

  typedef enum logic [1:0] {
    TGT_ROM     = 2'd0,
    TGT_CART    = 2'd1,
    TGT_SYS     = 2'd2,
    TGT_IGNORED = 2'd3
  } target_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RSTART,
    S_RWAIT,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  localparam logic [BANK_W-1:0] BANK_RESET [NUM_BANKS] = '{8'd0, 8'd0, 8'd1, 8'd2};

endpackage

@@ hdl/brmm_if.sv @@
// valid/ready channel interfaces for bus access items and result items
// depends on brmm_pkg
`timescale 1ns / 1ps

interface brmm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [brmm_pkg::BUS_W-1:0]  bus_address;
  logic [brmm_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output req_type, output bus_address, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input bus_address, input write_data,
                output ready);
endinterface

interface brmm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      target;
  logic [brmm_pkg::ROM_ADDR_W-1:0] rom_address;
  logic [brmm_pkg::DATA_W-1:0]     read_data;

  modport source (output valid, output target, output rom_address, output read_data,
                  input ready);
  modport sink (input valid, input target, input rom_address, input read_data,
                output ready);
endinterface

@@ hdl/banked_rom_memory_mapper.sv @@
// banked rom memory mapper: address decode, bank registers, ram and slot page sequencer
// depends on brmm_pkg, brmm_if, brmm_ram, brmm_mod and the defines header
//
// usage:
//   req carries one cpu bus access per item (req_type, bus_address, write_data);
//   rsp returns exactly one result item per access (target, rom_address, read_data).
//   cfg_we/cfg_wdata load the rom page count; write it only while the block is idle.
// sequencing:
//   rom reads, ignored writes and plain ram writes go from accept straight to the load state.
//   ram reads pass through the read state first, for the registered ram read.
//   writes to bank registers 1..3 pass through the remainder states, where the shared
//   remainder unit folds the bank value into the page count, one bit per cycle.
//   a page count write keeps req.ready low while the three
//   slot pages are recomputed through the same remainder unit.
//   req.ready is high only in the idle state, so one item is in work at a time.
// reset:
//   synchronous; banks 0,0,1,2, page count 1, all slots on page 0, cart ram off.
//   ram contents are not cleared; reads of unwritten entries return anything.
// stalls:
//   rsp holds its item in an output register until taken; the next req item can
//   be accepted meanwhile, and its result waits in the load state.
`timescale 1ns / 1ps
`include "banked_rom_memory_mapper_defines.svh"

module banked_rom_memory_mapper (
  input  logic                         clk,
  input  logic                         rst,
  brmm_req_if.sink                     req,
  brmm_rsp_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [brmm_pkg::CFG_W-1:0]   cfg_wdata
);

  brmm_pkg::state_t state, state_next;

  logic [brmm_pkg::BANK_W-1:0]  bank_registers [brmm_pkg::NUM_BANKS];
  logic [brmm_pkg::PAGE_W-1:0]  slot_page [brmm_pkg::NUM_SLOTS];
  logic                         cart_ram_enable;
  logic [brmm_pkg::CFG_W-1:0]   page_count;
  logic                         cfg_pending;
  logic [1:0]                   slot_idx;
  logic [1:0]                   slot_last;
  logic                         from_cfg;

  logic [1:0]                      res_target;
  logic [brmm_pkg::ROM_ADDR_W-1:0] res_rom_address;
  logic [brmm_pkg::DATA_W-1:0]     res_read_data;
  logic                            res_cart;

  logic                            out_valid;
  logic [1:0]                      out_target;
  logic [brmm_pkg::ROM_ADDR_W-1:0] out_rom_address;
  logic [brmm_pkg::DATA_W-1:0]     out_read_data;

  logic                            in_ready;
  logic                            accept;
  logic                            load_out;
  logic                            mod_start;
  logic                            cfg_remap;
  logic                            slot_wr;
  logic                            slot_advance;

  logic [brmm_pkg::NEFF_W-1:0]     n_eff;
  brmm_pkg::mod_status_t           mod_st;
  logic [brmm_pkg::PAGE_W-1:0]     mod_rem;

  brmm_pkg::target_t               dec_target;
  logic [brmm_pkg::ROM_ADDR_W-1:0] dec_rom_address;
  logic                            dec_ram_read;
  logic                            dec_cart;
  logic                            dec_cart_we;
  logic                            dec_sys_we;
  logic                            dec_bank_wr;
  logic [brmm_pkg::BANK_IDX_W-1:0] dec_bank_idx;

  logic [brmm_pkg::RAM_AW-1:0]     ram_addr;
  logic [brmm_pkg::DATA_W-1:0]     sys_rdata;
  logic [brmm_pkg::DATA_W-1:0]     cart_rdata;

  // effective page count, 1..MAX_PAGES
  always_comb begin
    priority if (page_count == '0) begin
      n_eff = brmm_pkg::NEFF_W'(1);
    end else if (page_count > brmm_pkg::CFG_W'(brmm_pkg::MAX_PAGES)) begin
      n_eff = brmm_pkg::NEFF_W'(brmm_pkg::MAX_PAGES);
    end else begin
      n_eff = page_count[brmm_pkg::NEFF_W-1:0];
    end
  end

  // address decode
  always_comb begin
    dec_target      = brmm_pkg::TGT_ROM;
    dec_rom_address = '0;
    dec_ram_read    = 1'b0;
    dec_cart        = 1'b0;
    dec_cart_we     = 1'b0;
    dec_sys_we      = 1'b0;
    dec_bank_wr     = 1'b0;
    dec_bank_idx    = req.bus_address[brmm_pkg::BANK_IDX_W-1:0];
    if (!req.req_type) begin
      priority if (req.bus_address <= brmm_pkg::FIXED_END) begin
        dec_rom_address = brmm_pkg::ROM_ADDR_W'(req.bus_address[brmm_pkg::OFFSET_W-1:0]);
      end else if (req.bus_address <= brmm_pkg::SLOT0_END) begin
        dec_rom_address = {slot_page[0], req.bus_address[brmm_pkg::OFFSET_W-1:0]};
      end else if (req.bus_address <= brmm_pkg::SLOT1_END) begin
        dec_rom_address = {slot_page[1], req.bus_address[brmm_pkg::OFFSET_W-1:0]};
      end else if (req.bus_address <= brmm_pkg::SLOT2_END) begin
        if (cart_ram_enable) begin
          dec_target   = brmm_pkg::TGT_CART;
          dec_ram_read = 1'b1;
          dec_cart     = 1'b1;
        end else begin
          dec_rom_address = {slot_page[2], req.bus_address[brmm_pkg::OFFSET_W-1:0]};
        end
      end else begin
        dec_target   = brmm_pkg::TGT_SYS;
        dec_ram_read = 1'b1;
      end
    end else begin
      priority if (req.bus_address <= brmm_pkg::SLOT1_END) begin
        dec_target = brmm_pkg::TGT_IGNORED;
      end else if (req.bus_address <= brmm_pkg::SLOT2_END) begin
        if (cart_ram_enable) begin
          dec_target  = brmm_pkg::TGT_CART;
          dec_cart_we = 1'b1;
        end else begin
          dec_target = brmm_pkg::TGT_IGNORED;
        end
      end else begin
        dec_target  = brmm_pkg::TGT_SYS;
        dec_sys_we  = 1'b1;
        dec_bank_wr = (req.bus_address >= brmm_pkg::BANK_BASE);
      end
    end
  end

  assign ram_addr = req.bus_address[brmm_pkg::RAM_AW-1:0];

  brmm_ram #(
    .WIDTH (brmm_pkg::DATA_W),
    .DEPTH (brmm_pkg::RAM_DEPTH)
  ) u_sys_ram (
    .clk   (clk),
    .we    (accept && dec_sys_we),
    .addr  (ram_addr),
    .wdata (req.write_data),
    .rdata (sys_rdata)
  );

  brmm_ram #(
    .WIDTH (brmm_pkg::DATA_W),
    .DEPTH (brmm_pkg::RAM_DEPTH)
  ) u_cart_ram (
    .clk   (clk),
    .we    (accept && dec_cart_we),
    .addr  (ram_addr),
    .wdata (req.write_data),
    .rdata (cart_rdata)
  );

  brmm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (bank_registers[slot_idx + 2'd1]),
    .divisor   (n_eff),
    .status    (mod_st),
    .remainder (mod_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brmm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    load_out     = 1'b0;
    mod_start    = 1'b0;
    cfg_remap    = 1'b0;
    slot_wr      = 1'b0;
    slot_advance = 1'b0;
    unique case (state)
      brmm_pkg::S_IDLE: begin
        if (cfg_pending) begin
          cfg_remap  = 1'b1;
          state_next = brmm_pkg::S_RSTART;
        end else begin
          in_ready = !cfg_we;
          if (req.valid && !cfg_we) begin
            priority if (dec_ram_read) begin
              state_next = brmm_pkg::S_READ;
            end else if (dec_bank_wr && dec_bank_idx != '0) begin
              state_next = brmm_pkg::S_RSTART;
            end else begin
              state_next = brmm_pkg::S_LOAD;
            end
          end
        end
      end
      brmm_pkg::S_READ: begin
        state_next = brmm_pkg::S_LOAD;
      end
      brmm_pkg::S_RSTART: begin
        mod_start  = 1'b1;
        state_next = brmm_pkg::S_RWAIT;
      end
      brmm_pkg::S_RWAIT: begin
        if (mod_st.done) begin
          slot_wr = 1'b1;
          if (slot_idx == slot_last) begin
            state_next = from_cfg ? brmm_pkg::S_IDLE : brmm_pkg::S_LOAD;
          end else begin
            slot_advance = 1'b1;
            state_next   = brmm_pkg::S_RSTART;
          end
        end
      end
      brmm_pkg::S_LOAD: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = brmm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = brmm_pkg::S_IDLE;
      end
    endcase
  end

  assign accept    = req.valid && in_ready;
  assign req.ready = in_ready;

  // bank registers, slot pages and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brmm_pkg::NUM_BANKS; i++) begin
        bank_registers[i] <= brmm_pkg::BANK_RESET[i];
      end
      for (int i = 0; i < brmm_pkg::NUM_SLOTS; i++) begin
        slot_page[i] <= '0;
      end
      cart_ram_enable <= 1'b0;
      page_count      <= brmm_pkg::PAGE_CNT_RESET;
      cfg_pending     <= 1'b0;
      slot_idx        <= '0;
      slot_last       <= '0;
      from_cfg        <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_count  <= cfg_wdata;
        cfg_pending <= 1'b1;
      end else if (cfg_remap) begin
        cfg_pending <= 1'b0;
      end
      if (cfg_remap) begin
        slot_idx  <= 2'd0;
        slot_last <= 2'(brmm_pkg::NUM_SLOTS - 1);
        from_cfg  <= 1'b1;
      end else if (accept && dec_bank_wr) begin
        bank_registers[dec_bank_idx] <= req.write_data;
        if (dec_bank_idx == '0) begin
          cart_ram_enable <= |(req.write_data & brmm_pkg::CART_EN_MASK);
        end else begin
          slot_idx  <= 2'(dec_bank_idx) - 2'd1;
          slot_last <= 2'(dec_bank_idx) - 2'd1;
          from_cfg  <= 1'b0;
        end
      end else if (slot_advance) begin
        slot_idx <= slot_idx + 2'd1;
      end
      if (slot_wr) begin
        slot_page[slot_idx] <= mod_rem;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      res_target      <= dec_target;
      res_rom_address <= dec_rom_address;
      res_read_data   <= '0;
      res_cart        <= dec_cart;
    end else if (state == brmm_pkg::S_READ) begin
      res_read_data <= res_cart ? cart_rdata : sys_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_target      <= res_target;
      out_rom_address <= res_rom_address;
      out_read_data   <= res_read_data;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.target      = out_target;
  assign rsp.rom_address = out_rom_address;
  assign rsp.read_data   = out_read_data;

  `BRMM_ASSERT(a_accept_leaves_idle, clk, rst, accept |=> state != brmm_pkg::S_IDLE)
  `BRMM_ASSERT(a_mod_done_in_wait, clk, rst, mod_st.done |-> state == brmm_pkg::S_RWAIT)
  `BRMM_ASSERT(a_slot_in_range, clk, rst,
    (state == brmm_pkg::S_IDLE && !cfg_pending) |-> (brmm_pkg::NEFF_W'(slot_page[0]) < n_eff
    && brmm_pkg::NEFF_W'(slot_page[1]) < n_eff && brmm_pkg::NEFF_W'(slot_page[2]) < n_eff))
  `BRMM_ASSERT(a_ram_result_no_rom_addr, clk, rst,
    (out_valid && out_target != brmm_pkg::TGT_ROM) |-> out_rom_address == '0)
  `BRMM_ASSERT(a_start_when_free, clk, rst, mod_start |-> !mod_st.busy)

endmodule

@@ hdl/brmm_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module brmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/brmm_mod.sv @@
// shared remainder unit: bank value modulo page count, one bit per cycle
// depends on brmm_pkg
`timescale 1ns / 1ps

module brmm_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [brmm_pkg::BANK_W-1:0]   dividend,
  input  logic [brmm_pkg::NEFF_W-1:0]   divisor,
  output brmm_pkg::mod_status_t         status,
  output logic [brmm_pkg::PAGE_W-1:0]   remainder
);

  logic                          busy;
  logic                          done;
  logic [brmm_pkg::STEP_W-1:0]   count;
  logic [brmm_pkg::BANK_W-1:0]   dvd;
  logic [brmm_pkg::NEFF_W-1:0]   div;
  logic [brmm_pkg::PAGE_W-1:0]   rem;
  logic [brmm_pkg::NEFF_W-1:0]   trial;
  logic [brmm_pkg::NEFF_W-1:0]   diff;
  logic [brmm_pkg::PAGE_W-1:0]   rem_next;

  always_comb begin
    trial = {rem, dvd[brmm_pkg::BANK_W-1]};
    diff  = trial - div;
    if (trial >= div) begin
      rem_next = diff[brmm_pkg::PAGE_W-1:0];
    end else begin
      rem_next = trial[brmm_pkg::PAGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == brmm_pkg::STEP_W'(brmm_pkg::BANK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[brmm_pkg::BANK_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;

endmodule

@@ test/tb_banked_rom_memory_mapper.sv @@
// testbench for banked_rom_memory_mapper: random and directed bus access items, a paging
// predictor in a scoreboard class, random idling on both channels, page count phases
// depends on brmm_pkg, brmm_if and the banked_rom_memory_mapper rtl
`timescale 1ns / 1ps

import brmm_pkg::*;

localparam logic REQ_READ  = 1'b0;
localparam logic REQ_WRITE = 1'b1;

typedef struct packed {
  target_t                 target;
  logic [ROM_ADDR_W-1:0]   rom_address;
  logic [DATA_W-1:0]       read_data;
} mapper_result_t;

class mapper_scoreboard;
  logic [BANK_W-1:0] bank_reg [NUM_BANKS];
  logic [PAGE_W-1:0] slot_page [NUM_SLOTS];
  logic              cart_on;
  logic [CFG_W-1:0]  page_count;
  logic [DATA_W-1:0] sys_mem [RAM_DEPTH];
  logic [DATA_W-1:0] cart_mem [RAM_DEPTH];
  bit                sys_seen [RAM_DEPTH];
  bit                cart_seen [RAM_DEPTH];
  int                sys_written [$];
  int                cart_written [$];
  mapper_result_t    expected_q [$];
  int                errors;

  function new();
    for (int i = 0; i < NUM_BANKS; i++) bank_reg[i] = BANK_RESET[i];
    page_count = PAGE_CNT_RESET;
    errors = 0;
    remap();
  endfunction

  function void remap();
    int unsigned pages;
    pages = page_count;
    if (pages == 0) pages = 1;
    if (pages > MAX_PAGES) pages = MAX_PAGES;
    for (int i = 0; i < NUM_SLOTS; i++) slot_page[i] = PAGE_W'(bank_reg[i+1] % pages);
    cart_on = (bank_reg[0] & CART_EN_MASK) != '0;
  endfunction

  function void set_page_count(logic [CFG_W-1:0] value);
    page_count = value;
    remap();
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_access(logic kind, logic [BUS_W-1:0] addr, logic [DATA_W-1:0] data);
    mapper_result_t r;
    int idx;
    idx = int'(addr[RAM_AW-1:0]);
    r.target = TGT_IGNORED;
    r.rom_address = '0;
    r.read_data = '0;
    if (kind == REQ_READ) begin
      if (addr <= FIXED_END) begin
        r.target = TGT_ROM;
        r.rom_address = ROM_ADDR_W'(addr);
      end else if (addr <= SLOT0_END) begin
        r.target = TGT_ROM;
        r.rom_address = {slot_page[0], addr[OFFSET_W-1:0]};
      end else if (addr <= SLOT1_END) begin
        r.target = TGT_ROM;
        r.rom_address = {slot_page[1], addr[OFFSET_W-1:0]};
      end else if (addr <= SLOT2_END && !cart_on) begin
        r.target = TGT_ROM;
        r.rom_address = {slot_page[2], addr[OFFSET_W-1:0]};
      end else if (addr <= SLOT2_END) begin
        r.target = TGT_CART;
        r.read_data = cart_mem[idx];
      end else begin
        r.target = TGT_SYS;
        r.read_data = sys_mem[idx];
      end
    end else if (addr <= SLOT1_END || (addr <= SLOT2_END && !cart_on)) begin
      r.target = TGT_IGNORED;
    end else if (addr <= SLOT2_END) begin
      r.target = TGT_CART;
      cart_mem[idx] = data;
      if (!cart_seen[idx]) begin
        cart_seen[idx] = 1'b1;
        cart_written.push_back(idx);
      end
    end else begin
      r.target = TGT_SYS;
      sys_mem[idx] = data;
      if (!sys_seen[idx]) begin
        sys_seen[idx] = 1'b1;
        sys_written.push_back(idx);
      end
      if (addr >= BANK_BASE) begin
        bank_reg[addr[BANK_IDX_W-1:0]] = data;
        remap();
      end
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [1:0] tgt, logic [ROM_ADDR_W-1:0] rom_addr,
                             logic [DATA_W-1:0] rd);
    mapper_result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: result item with none pending, target %0d rom_address %h read_data %h",
               $time, tgt, rom_addr, rd);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (tgt !== exp_r.target) begin
      $display("%0t: target mismatch, expected %0d actual %0d", $time, exp_r.target, tgt);
      errors++;
    end
    if (rom_addr !== exp_r.rom_address) begin
      $display("%0t: rom_address mismatch, expected %h actual %h",
               $time, exp_r.rom_address, rom_addr);
      errors++;
    end
    if (rd !== exp_r.read_data) begin
      $display("%0t: read_data mismatch, expected %h actual %h", $time, exp_r.read_data, rd);
      errors++;
    end
  endfunction
endclass

module tb_banked_rom_memory_mapper;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int NUM_PHASES       = 11;
  localparam int PHASE_COUNTS [NUM_PHASES] = '{0, 1, 2, 3, 5, 64, 100, 255, 257, 511, 256};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned cycle_count;
  bit send_calm;
  bit take_calm;
  int sent_items;
  int taken_items;
  mapper_scoreboard sb;

  brmm_req_if req_ch ();
  brmm_rsp_if rsp_ch ();

  banked_rom_memory_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_access(input logic kind, input logic [BUS_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.bus_address <= addr;
    req_ch.write_data  <= data;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_access(kind, addr, data);
    sent_items++;
    if (sent_items % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic write_page_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_page_count(value);
  endtask

  task automatic make_access(output logic kind, output logic [BUS_W-1:0] addr,
                             output logic [DATA_W-1:0] data);
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    kind = REQ_READ;
    data = DATA_W'($urandom);
    addr = BUS_W'($urandom);
    if (pick < 20) begin
      addr = BUS_W'($urandom_range(0, sb.cart_on ? int'(SLOT1_END) : int'(SLOT2_END)));
    end else if (pick < 32) begin
      kind = REQ_WRITE;
      addr = BUS_W'($urandom_range(0, sb.cart_on ? int'(SLOT1_END) : int'(SLOT2_END)));
    end else if (pick < 47) begin
      kind = REQ_WRITE;
      addr = BUS_W'($urandom_range(int'(SLOT2_END) + 1, int'(BANK_BASE) - 1));
    end else if (pick < 62 && sb.sys_written.size() > 0) begin
      idx = sb.sys_written[$urandom_range(0, sb.sys_written.size() - 1)];
      addr = {2'b11, 1'($urandom), idx[RAM_AW-1:0]};
    end else if (pick < 72) begin
      kind = REQ_WRITE;
      if (sb.cart_on) begin
        addr = {2'b10, 14'($urandom)};
      end else begin
        addr = BANK_BASE;
        data = data | CART_EN_MASK;
      end
    end else if (pick < 85) begin
      if (sb.cart_on && sb.cart_written.size() > 0) begin
        idx = sb.cart_written[$urandom_range(0, sb.cart_written.size() - 1)];
        addr = {2'b10, 1'($urandom), idx[RAM_AW-1:0]};
      end else begin
        addr = BUS_W'($urandom_range(0, int'(SLOT0_END)));
      end
    end else begin
      kind = REQ_WRITE;
      addr = {BANK_BASE[BUS_W-1:BANK_IDX_W], BANK_IDX_W'($urandom)};
    end
  endtask

  // result side: random stall before each item
  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      stall = take_calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_result(rsp_ch.target, rsp_ch.rom_address, rsp_ch.read_data);
      taken_items++;
      if (taken_items % 50 == 0) take_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic             kind;
    logic [BUS_W-1:0] addr;
    logic [DATA_W-1:0] data;
    sb = new();
    send_calm = 1'b0;
    take_calm = 1'b0;
    sent_items = 0;
    taken_items = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_READ;
    req_ch.bus_address = '0;
    req_ch.write_data = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: region edges, ignored writes, mirrors, bank loads, cart ram on and off
    write_page_count(9'd256);
    send_access(REQ_READ, 16'h0000, 8'h00);
    send_access(REQ_READ, FIXED_END, 8'hFF);
    send_access(REQ_READ, 16'h0400, 8'h00);
    send_access(REQ_READ, SLOT0_END, 8'h00);
    send_access(REQ_READ, 16'h4000, 8'h00);
    send_access(REQ_READ, SLOT1_END, 8'h00);
    send_access(REQ_READ, 16'h8000, 8'h00);
    send_access(REQ_READ, SLOT2_END, 8'h00);
    send_access(REQ_WRITE, 16'h0000, 8'hFF);
    send_access(REQ_WRITE, SLOT2_END, 8'h55);
    send_access(REQ_WRITE, 16'hC000, 8'hA5);
    send_access(REQ_READ, 16'hE000, 8'h00);
    send_access(REQ_WRITE, 16'hDFFF, 8'h5A);
    send_access(REQ_READ, 16'hFFFF, 8'h00);
    send_access(REQ_WRITE, 16'hFFFF, 8'hFF);
    send_access(REQ_WRITE, 16'hFFFE, 8'h80);
    send_access(REQ_WRITE, 16'hFFFD, 8'h7F);
    send_access(REQ_READ, 16'h8000, 8'h00);
    send_access(REQ_READ, 16'h4001, 8'h00);
    send_access(REQ_READ, 16'h0400, 8'h00);
    send_access(REQ_WRITE, BANK_BASE, CART_EN_MASK);
    send_access(REQ_WRITE, 16'h8000, 8'h11);
    send_access(REQ_WRITE, SLOT2_END, 8'h22);
    send_access(REQ_READ, 16'hA000, 8'h00);
    send_access(REQ_READ, 16'h9FFF, 8'h00);
    send_access(REQ_WRITE, SLOT1_END, 8'h33);
    send_access(REQ_WRITE, BANK_BASE, 8'h00);
    send_access(REQ_READ, SLOT2_END, 8'h00);

    for (int p = 0; p <= NUM_PHASES; p++) begin
      if (p < NUM_PHASES) write_page_count(CFG_W'(PHASE_COUNTS[p]));
      else write_page_count(CFG_W'($urandom_range(1, MAX_PAGES)));
      repeat (ITEMS_PER_PHASE) begin
        make_access(kind, addr, data);
        send_access(kind, addr, data);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
